// ----- hdl/rmm_pkg.sv -----
`timescale 1ns / 1ps

package rmm_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QBITS           = SINE_TABLE_BITS - 2;
  localparam int QSIZE           = 1 << QBITS;

  localparam int SAMPLE_W = 16;
  localparam int MIX_W    = 16;
  localparam int STEP_W   = 32;

  localparam logic [16:0] ONE_Q15     = 17'd32768;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // apb register map, index = paddr[2]
  localparam int          ADDR_W          = 3;
  localparam logic        REG_PHASE_STEP  = 1'b0;
  localparam logic        REG_MIX_WEIGHT  = 1'b1;
  localparam logic [15:0] MIX_RESET       = 16'd16384;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [15:0]         sine;
  } rmm_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rmm_qstat_t;

  typedef logic [QSIZE-1:0][14:0] qtab_t;

  // first-quadrant sine magnitude in q15, integer taylor series in q30
  function automatic logic [14:0] sine_mag(input logic [QBITS:0] eff);
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    a    = (HALF_PI_Q30 * 64'(eff)) >> QBITS;
    term = a;
    sum  = a;
    term = (((term * a) >> 30) * a >> 30) / 64'd6;
    sum  = sum - term;
    term = (((term * a) >> 30) * a >> 30) / 64'd20;
    sum  = sum + term;
    term = (((term * a) >> 30) * a >> 30) / 64'd42;
    sum  = sum - term;
    term = (((term * a) >> 30) * a >> 30) / 64'd72;
    sum  = sum + term;
    term = (((term * a) >> 30) * a >> 30) / 64'd110;
    sum  = sum - term;
    term = (((term * a) >> 30) * a >> 30) / 64'd156;
    sum  = sum + term;
    term = (((term * a) >> 30) * a >> 30) / 64'd210;
    sum  = sum - term;
    term = (((term * a) >> 30) * a >> 30) / 64'd272;
    sum  = sum + term;
    mag  = (sum + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k < QSIZE; k++) begin
      t[k] = sine_mag((QBITS+1)'(k));
    end
    return t;
  endfunction

  localparam qtab_t       QTAB  = build_qtab();
  localparam logic [14:0] QPEAK = sine_mag((QBITS+1)'(QSIZE));

endpackage

// ----- hdl/ring_modulator_mix.sv -----
`timescale 1ns / 1ps

// Ring modulator with sine carrier and dry/wet blend. Each transfer on the s_ side carries one
// signed 16-bit sample; one result sample leaves on the m_ side per input, in order:
// y = (1 - mix) * x + mix * sin(phase) * x, truncated toward zero, with mix_weight in Q1.15
// (values above 32768 act as 32768). The phase is a 32-bit fraction of a turn, cleared by
// reset, and moves by phase_step after each sample; the sine comes from a quarter-wave table
// addressed by the top 10 phase bits. The input side holds each sample until it is written
// into a two-entry queue and takes no new sample meanwhile; the back end handles one sample
// at a time in four steps (queue read, mix multiply, sample multiply, truncation into the
// output register) and reads the next only once its result is loaded. Registers:
// phase_step at 0x0, mix_weight at 0x4 (reset 16384); write them only while the block is idle.
module ring_modulator_mix
  import rmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [15:0] sample_in
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // [15:0] sample_out
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [STEP_W-1:0] phase_step;
  logic [MIX_W-1:0]  mix_weight;
  logic              cfg_wr;

  logic       push;
  logic       pop;
  rmm_item_t  push_item;
  rmm_item_t  pop_item;
  rmm_qstat_t qstat;
  logic signed [SAMPLE_W-1:0] out_sample;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      mix_weight <= MIX_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PHASE_STEP: phase_step <= pwdata[STEP_W-1:0];
        REG_MIX_WEIGHT: mix_weight <= pwdata[MIX_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PHASE_STEP: prdata = phase_step;
      REG_MIX_WEIGHT: prdata = {16'b0, mix_weight};
      default:        prdata = '0;
    endcase
  end

  rmm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .phase_step (phase_step),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_sample  (s_tdata),
    .push       (push),
    .push_item  (push_item),
    .qstat      (qstat)
  );

  rmm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  rmm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mix_weight (mix_weight),
    .qstat      (qstat),
    .pop        (pop),
    .pop_item   (pop_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (out_sample)
  );

  assign m_tdata = out_sample;

  // queue never written while full
  assert property (@(posedge clk) disable iff (rst) qstat.full |-> !push)
    else $error("queue overflow");

  // queue never read while empty
  assert property (@(posedge clk) disable iff (rst) qstat.empty |-> !pop)
    else $error("queue underflow");

  // input side only stalls after taking a sample
  assert property (@(posedge clk) disable iff (rst)
      (s_tvalid && s_tready) |=> !s_tready)
    else $error("front accepted a sample without holding it");

  // every queue write comes from a held sample, never in the cycle of a new transfer
  assert property (@(posedge clk) disable iff (rst) push |-> !s_tready)
    else $error("queue write without a held sample");

endmodule

// ----- hdl/rmm_front.sv -----
`timescale 1ns / 1ps

module rmm_front
  import rmm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic [STEP_W-1:0]          phase_step,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       push,
  output rmm_item_t                  push_item,
  input  rmm_qstat_t                 qstat
);

  logic                        busy;
  logic [PHASE_BITS-1:0]       phase;
  logic signed [SAMPLE_W-1:0]  sample;
  logic                        neg;
  logic [14:0]                 mag;

  logic [PHASE_BITS+STEP_W-1:0] step_wide;
  logic [PHASE_BITS-1:0]        step_al;
  logic [SINE_TABLE_BITS-1:0]   idx;
  logic [1:0]                   quad;
  logic [QBITS-1:0]             pos;
  logic [QBITS-1:0]             addr;
  logic                         at_peak;
  logic                         accept;

  // step scaled by 2^(PHASE_BITS-32), low bits dropped when narrower
  assign step_wide = {phase_step, PHASE_BITS'(0)};
  assign step_al   = step_wide[PHASE_BITS+STEP_W-1:STEP_W];

  assign idx     = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad    = idx[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
  assign pos     = idx[QBITS-1:0];
  // odd quadrants run backward; start of an odd quadrant is the peak
  assign at_peak = quad[0] && (pos == '0);
  assign addr    = quad[0] ? QBITS'(-pos) : pos;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign push     = busy && !qstat.full;

  assign push_item.sample = sample;
  assign push_item.sine   = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= '0;
    end else begin
      if (accept) begin
        busy  <= 1'b1;
        phase <= phase + step_al;
      end else if (push) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= in_sample;
      neg    <= quad[1];
      mag    <= at_peak ? QPEAK : QTAB[addr];
    end
  end

endmodule

// ----- hdl/rmm_fifo.sv -----
`timescale 1ns / 1ps

module rmm_fifo
  import rmm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rmm_item_t  push_item,
  input  logic       pop,
  output rmm_item_t  pop_item,
  output rmm_qstat_t qstat
);

  rmm_item_t           mem [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;

  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign pop_item    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

// ----- hdl/rmm_back.sv -----
`timescale 1ns / 1ps

module rmm_back
  import rmm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic [MIX_W-1:0]           mix_weight,
  input  rmm_qstat_t                 qstat,
  output logic                       pop,
  input  rmm_item_t                  pop_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL1 = 2'd1;
  localparam logic [1:0] B_MUL2 = 2'd2;
  localparam logic [1:0] B_RND  = 2'd3;

  logic [1:0]                 state;
  logic [1:0]                 state_next;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [15:0]         sine;
  logic signed [31:0]         gain;
  logic signed [47:0]         num;

  logic [16:0]                mix;
  logic [16:0]                dry;
  logic signed [33:0]         wet;
  logic signed [31:0]         gain_next;
  logic signed [47:0]         num_next;
  logic signed [47:0]         biased;
  logic                       load_out;

  // mix above one acts as one
  assign mix = ({1'b0, mix_weight} > ONE_Q15) ? ONE_Q15 : {1'b0, mix_weight};
  assign dry = ONE_Q15 - mix;
  assign wet = $signed({1'b0, mix}) * sine;

  assign gain_next = $signed({dry[16:0], 15'b0}) + wet[31:0];
  assign num_next  = gain * sample;

  // bias negatives so the arithmetic shift truncates toward zero
  assign biased = num + (num[47] ? 48'sh3FFF_FFFF : 48'sh0);

  assign pop      = (state == B_IDLE) && !qstat.empty;
  assign load_out = (state == B_RND) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (pop) state_next = B_MUL1;
      B_MUL1:  state_next = B_MUL2;
      B_MUL2:  state_next = B_RND;
      B_RND:   if (load_out) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sample <= pop_item.sample;
      sine   <= pop_item.sine;
    end
    if (state == B_MUL1) begin
      gain <= gain_next;
    end
    if (state == B_MUL2) begin
      num <= num_next;
    end
    if (load_out) begin
      out_sample <= biased[30+SAMPLE_W-1:30];
    end
  end

endmodule

// ----- tb/sv/tb_ring_modulator_mix.sv -----
`timescale 1ns / 1ps

module tb_ring_modulator_mix;
  import rmm_pkg::*;

  localparam int LUT_LEN = 1 << SINE_TABLE_BITS;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = 16'h0000;   // [15:0] sample_in
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;              // [15:0] sample_out
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = 32'h0;
  logic [31:0]       prdata;
  logic              pready;

  ring_modulator_mix DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // carrier state and register copies
  logic signed [15:0]  sine_lut [0:LUT_LEN-1];
  logic [PHASE_BITS-1:0] carrier_phase = '0;
  logic [31:0]         step_now = 32'h0;
  logic [15:0]         mix_now = MIX_RESET;

  logic [15:0] samples_to_send [$];
  logic [15:0] mixed_due [$];

  int  errors = 0;
  int  sent_count = 0;
  int  checked_count = 0;
  int  settings_count = 0;
  int  send_gap = 0;
  int  take_gap = 0;
  bit  calm = 1'b0;
  bit  hold_send = 1'b0;

  // quarter-wave taylor series in q30, rounded to q15, mirrored to the full turn
  function automatic void fill_sine_lut();
    longint unsigned ang, term, acc, mag, n;
    int unsigned quad, pos, eff;
    for (int k = 0; k < LUT_LEN; k++) begin
      quad = (k >> (SINE_TABLE_BITS - 2)) & 3;
      pos  = k & ((LUT_LEN >> 2) - 1);
      eff  = (quad & 1) ? ((LUT_LEN >> 2) - pos) : pos;
      ang  = (QUARTER_TURN_Q30 * eff) >> (SINE_TABLE_BITS - 2);
      term = ang;
      acc  = ang;
      for (n = 1; n <= 8; n++) begin
        term = (term * ang) >> 30;
        term = (term * ang) >> 30;
        term = term / ((2 * n) * (2 * n + 1));
        if (n & 1) acc = acc - term;
        else acc = acc + term;
      end
      mag = (acc + 64'd16384) >> 15;
      if (mag > 64'd32767) mag = 64'd32767;
      sine_lut[k] = (quad & 2) ? -16'(mag) : 16'(mag);
    end
  endfunction

  // one output sample; the carrier phase moves on afterwards
  function automatic logic [15:0] mixed_sample(input logic [15:0] raw);
    longint x, s, m, gain, num;
    x = longint'($signed(raw));
    s = sine_lut[carrier_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]];
    m = (mix_now > 16'd32768) ? 64'sd32768 : longint'(mix_now);
    gain = (64'sd32768 - m) * 64'sd32768 + m * s;
    num = gain * x;
    carrier_phase = carrier_phase + step_now;
    return 16'(num / 64'sd1073741824);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, $signed(got), $signed(want));
    errors++;
  endtask

  // sender: new sample after each transfer unless a gap or a hold is on
  always @(posedge clk) begin : drive_s
    logic        next_valid;
    logic [15:0] next_data;
    next_valid = s_tvalid;
    next_data  = s_tdata;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        mixed_due.push_back(mixed_sample(samples_to_send.pop_front()));
        sent_count++;
        next_valid = 1'b0;
        if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 12);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!hold_send && samples_to_send.size() > 0) begin
          next_valid = 1'b1;
          next_data  = samples_to_send[0];
        end
      end
    end
    s_tvalid <= next_valid;
    s_tdata  <= next_data;
  end

  // receiver: check each transfer against the oldest pending sample
  always @(posedge clk) begin : watch_m
    logic [15:0] want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (mixed_due.size() == 0) begin
          report_mismatch("output with nothing pending", m_tdata, 16'h0000);
        end else begin
          want = mixed_due.pop_front();
          if (m_tdata !== want) report_mismatch("sample_out", m_tdata, want);
          checked_count++;
        end
      end
      if (take_gap > 0) take_gap--;
      else if (!calm && $urandom_range(0, 9) == 0) take_gap = $urandom_range(1, 12);
    end
    m_tready <= !rst && (take_gap == 0);
  end

  task automatic write_reg(input logic reg_index, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_index)
      REG_PHASE_STEP: step_now = value;
      REG_MIX_WEIGHT: mix_now  = value[15:0];
      default:        ;
    endcase
    settings_count++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (samples_to_send.size() != 0 || mixed_due.size() != 0);
  endtask

  task automatic reconfigure(input logic [31:0] step_val, input logic [31:0] mix_val);
    wait_drained();
    repeat (8) @(posedge clk);
    write_reg(REG_PHASE_STEP, step_val);
    write_reg(REG_MIX_WEIGHT, mix_val);
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) samples_to_send.push_back(random_sample());
  endtask

  task automatic random_setting();
    logic [31:0] step_val;
    logic [31:0] mix_val;
    case ($urandom_range(0, 4))
      0: step_val = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      1: step_val = $urandom_range(1, 32'h0040_0000);
      default: step_val = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: mix_val = 32'd0;
      1: mix_val = 32'd32768;
      2: mix_val = $urandom_range(32769, 65535);
      default: mix_val = $urandom_range(0, 32768);
    endcase
    reconfigure(step_val, mix_val);
  endtask

  initial begin : stimulus
    int base;
    fill_sine_lut();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values: zero step, half mix, carrier at zero
    samples_to_send.push_back(16'h0000);
    samples_to_send.push_back(16'h0001);
    samples_to_send.push_back(16'hffff);
    samples_to_send.push_back(16'h7fff);
    samples_to_send.push_back(16'h8000);

    // fully wet, carrier walks one table entry per sample
    reconfigure(32'h0040_0000, 32'd32768);
    samples_to_send.push_back(16'h7fff);
    samples_to_send.push_back(16'h8000);
    samples_to_send.push_back(16'd12345);
    samples_to_send.push_back(16'hffff);
    samples_to_send.push_back(16'h0000);
    samples_to_send.push_back(16'h7fff);

    // mix above one acts as fully wet, phase step at its maximum
    reconfigure(32'hffff_ffff, 32'd65535);
    samples_to_send.push_back(16'h8000);
    samples_to_send.push_back(16'h7fff);
    samples_to_send.push_back(16'h0001);
    samples_to_send.push_back(16'hffff);

    // quarter turn per sample, one sample in each quadrant of the sine
    reconfigure(32'h4000_0000, 32'd32768);
    samples_to_send.push_back(16'h8000);
    samples_to_send.push_back(16'h8000);
    samples_to_send.push_back(16'h7fff);
    samples_to_send.push_back(16'h7fff);
    samples_to_send.push_back(16'h8000);

    // dry only
    reconfigure(32'h0100_0000, 32'd0);
    samples_to_send.push_back(16'h8000);
    samples_to_send.push_back(16'h7fff);
    samples_to_send.push_back(16'hffff);

    for (int p = 0; p < 8; p++) begin
      random_setting();
      if (p == 7) calm = 1'b1;
      if (p == 3) begin
        base = sent_count;
        queue_random(100);
        while (sent_count < base + 50) @(posedge clk);
        // let the pipeline run dry before sending the rest
        hold_send = 1'b1;
        repeat (2) @(posedge clk);
        while (mixed_due.size() != 0 || s_tvalid) @(posedge clk);
        repeat (5) @(posedge clk);
        hold_send = 1'b0;
      end else begin
        queue_random(100);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mixed_due.size() != 0) report_mismatch("samples never returned", 16'h0, 16'h0);

    $display("sent %0d samples over %0d register writes, checked %0d outputs",
             sent_count, settings_count, checked_count);
    $display("covered dry, partial, fully wet and over-range mix with zero to full-turn steps");
    if (errors == 0) begin
      $display("ring_modulator_mix: match");
    end else begin
      $display("ring_modulator_mix: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("ring_modulator_mix: mismatch");
    $finish;
  end

endmodule
